// File: rtl/core/msht_pkg.sv
// ----------------------------------------------------------------------------
// Miss status holding table package
// Shared widths, request and error codes, search result type and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package msht_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int ADDR_W          = 64;
   localparam int TIME_W          = 32;
   localparam int LAT_W           = 16;
   localparam int SLOT_W          = 4;
   localparam int TAG_W           = 8;
   localparam int STAMP_W         = 16;
   localparam int OFFS_W          = 6;
   localparam int REM_W           = 16;
   localparam int ERR_W           = 2;
   localparam int REQ_W           = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;

   localparam logic [OFFS_W-1:0] OFFSET_RESET = 6'd6;

   // register index, taken from paddr[2]
   localparam logic CSR_ENABLED = 1'b0;
   localparam logic CSR_OFFSET  = 1'b1;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOOKUP   = 2'd0,
      REQ_ADD      = 2'd1,
      REQ_COMPLETE = 2'd2,
      REQ_NONE     = 2'd3
   } req_code_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_NEG   = 2'd2,
      ERR_EMPTY = 2'd3
   } err_code_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] match_slot;
      logic              free_found;
      logic [SLOT_W-1:0] free_slot;
   } search_type;

   function automatic logic [ADDR_W-1:0] line_mask(input logic [OFFS_W-1:0] offset);
      line_mask = ~((64'd1 << offset) - 64'd1);
   endfunction

   function automatic logic [REM_W-1:0] sat16(input logic [TIME_W-1:0] v);
      if (v > TIME_W'(16'hFFFF)) begin
         sat16 = 16'hFFFF;
      end else begin
         sat16 = v[REM_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/miss_status_holding_table_core.sv
// ----------------------------------------------------------------------------
// Miss status holding table core
// A request is taken into the request register and answered from the response
// register, with rsp_valid strobed; the line compare, oldest-match tree and slot
// update run combinationally between the request and response registers.
// Throughput one request per cycle; busy is high only in reset and the cycle
// after it. Sync reset clears valid bits, stamp counter and CSRs (enabled 0,
// offset_bits 6); payload storage is not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module miss_status_holding_table_core #(
   parameter int ENTRIES = msht_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [msht_pkg::REQ_W-1:0]        req_type,
   input  wire logic [msht_pkg::ADDR_W-1:0]       req_address,
   input  wire logic [msht_pkg::LAT_W-1:0]        req_miss_latency,
   input  wire logic [msht_pkg::TIME_W-1:0]       req_now,
   input  wire logic [msht_pkg::SLOT_W-1:0]       req_slot,
   input  wire logic [msht_pkg::TAG_W-1:0]        req_requester_tag,
   // response channel
   output logic                                   rsp_valid,
   output logic                                   rsp_hit,
   output logic [msht_pkg::REM_W-1:0]             rsp_remaining,
   output logic [msht_pkg::SLOT_W-1:0]            rsp_assigned_slot,
   output logic                                   rsp_linked,
   output logic [msht_pkg::LAT_W-1:0]             rsp_wait_cycles,
   output logic                                   rsp_finished_valid,
   output logic [msht_pkg::TAG_W-1:0]             rsp_finished_tag,
   output logic [msht_pkg::ERR_W-1:0]             rsp_error,
   // CSR port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [msht_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [msht_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [msht_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);
   import msht_pkg::*;

   localparam int SlotLimit = (ENTRIES < 16) ? ENTRIES : 16;
   localparam int IdxW      = $clog2(SlotLimit);

   // ---------------------------------------------------------------- CSRs
   logic              enabled_ff, enabled_in;
   logic [OFFS_W-1:0] offset_ff, offset_in;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      enabled_in = enabled_ff;
      offset_in  = offset_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_ENABLED: enabled_in = pwdata[0];
            default:     offset_in  = pwdata[OFFS_W-1:0];
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_ENABLED: prdata = {{(CSR_DATA_W-1){1'b0}}, enabled_ff};
         default:     prdata = {{(CSR_DATA_W-OFFS_W){1'b0}}, offset_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         offset_ff  <= OFFSET_RESET;
      end else begin
         enabled_ff <= enabled_in;
         offset_ff  <= offset_in;
      end
   end

   // ------------------------------------------------------ request register
   // Hold busy during reset and the cycle after it; otherwise take a request
   // every cycle.
   logic               busy_ff;
   logic               accept;
   logic               req_valid_ff;
   logic [REQ_W-1:0]   req_type_ff;
   logic [ADDR_W-1:0]  req_address_ff;
   logic [LAT_W-1:0]   req_latency_ff;
   logic [TIME_W-1:0]  req_now_ff;
   logic [SLOT_W-1:0]  req_slot_ff;
   logic [TAG_W-1:0]   req_tag_ff;

   assign busy   = busy_ff;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_type_ff    <= req_type;
         req_address_ff <= req_address;
         req_latency_ff <= req_miss_latency;
         req_now_ff     <= req_now;
         req_slot_ff    <= req_slot;
         req_tag_ff     <= req_requester_tag;
      end
   end

   // ---------------------------------------------------------- table state
   logic [SlotLimit-1:0] entry_valid_ff, entry_valid_in;
   logic [ADDR_W-1:0]    line_address_ff [SlotLimit];
   logic [TIME_W-1:0]    end_time_ff     [SlotLimit];
   logic                 link_flag_ff    [SlotLimit];
   logic [TAG_W-1:0]     owner_tag_ff    [SlotLimit];
   logic [STAMP_W-1:0]   insert_stamp_ff [SlotLimit];
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;

   // ----------------------------------------------------------- search
   logic [ADDR_W-1:0] line;
   search_type        search;

   assign line = req_address_ff & line_mask(offset_ff);

   msht_search #(
      .ENTRIES (ENTRIES)
   ) u_search (
      .entry_valid   (entry_valid_ff),
      .line_address  (line_address_ff),
      .insert_stamp  (insert_stamp_ff),
      .stamp_counter (stamp_ff),
      .line          (line),
      .result        (search)
   );

   // matched entry and the time left on it
   logic [IdxW-1:0]   match_idx;
   logic [IdxW-1:0]   free_idx;
   logic [IdxW-1:0]   done_idx;
   logic [TIME_W-1:0] match_end;
   logic [TIME_W-1:0] diff;
   logic              neg;
   logic              as_link;
   logic              slot_ok;

   assign match_idx = search.match_slot[IdxW-1:0];
   assign free_idx  = search.free_slot[IdxW-1:0];
   assign done_idx  = req_slot_ff[IdxW-1:0];
   assign match_end = end_time_ff[match_idx];
   assign diff      = match_end - req_now_ff;
   assign neg       = search.hit && diff[TIME_W-1];
   assign as_link   = search.hit && !link_flag_ff[match_idx];
   assign slot_ok   = ({1'b0, req_slot_ff} < (SLOT_W+1)'(SlotLimit)) &&
                      entry_valid_ff[done_idx];

   // ------------------------------------------------------- request logic
   logic               wr_en;
   logic [TIME_W-1:0]  wr_end;
   logic               hit_in;
   logic [REM_W-1:0]   remaining_in;
   logic [SLOT_W-1:0]  aslot_in;
   logic               linked_in;
   logic [LAT_W-1:0]   wait_in;
   logic               fin_in;
   logic [TAG_W-1:0]   ftag_in;
   err_code_type       err_in;

   always_comb begin
      entry_valid_in = entry_valid_ff;
      stamp_in       = stamp_ff;
      wr_en          = 1'b0;
      wr_end         = req_now_ff + TIME_W'(req_latency_ff);
      hit_in         = 1'b0;
      remaining_in   = '0;
      aslot_in       = '0;
      linked_in      = 1'b0;
      wait_in        = '0;
      fin_in         = 1'b0;
      ftag_in        = '0;
      err_in         = ERR_NONE;
      if (req_valid_ff) begin
         case (req_code_type'(req_type_ff))
            REQ_LOOKUP: begin
               if (enabled_ff) begin
                  hit_in       = search.hit;
                  remaining_in = (search.hit && !neg) ? sat16(diff) : '0;
                  if (neg) begin
                     err_in = ERR_NEG;
                  end
               end
            end
            REQ_ADD: begin
               if (!enabled_ff) begin
                  // untracked: tell the requester at once
                  fin_in  = 1'b1;
                  ftag_in = req_tag_ff;
               end else begin
                  hit_in       = search.hit;
                  remaining_in = (search.hit && !neg) ? sat16(diff) : '0;
                  if (as_link && neg) begin
                     err_in = ERR_NEG;
                  end else if (!search.free_found) begin
                     err_in = ERR_FULL;
                  end else begin
                     wr_en                    = 1'b1;
                     entry_valid_in[free_idx] = 1'b1;
                     stamp_in                 = stamp_ff + STAMP_W'(1);
                     aslot_in                 = search.free_slot;
                     linked_in                = as_link;
                     if (as_link) begin
                        wr_end  = match_end;
                        wait_in = sat16(diff);
                     end else begin
                        wait_in = req_latency_ff;
                     end
                  end
               end
            end
            REQ_COMPLETE: begin
               if (slot_ok) begin
                  entry_valid_in[done_idx] = 1'b0;
                  fin_in                   = 1'b1;
                  ftag_in                  = owner_tag_ff[done_idx];
               end else begin
                  err_in = ERR_EMPTY;
               end
            end
            default: begin
               // no request: answer all zero
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         stamp_ff       <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         stamp_ff       <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_address_ff[free_idx] <= line;
         end_time_ff[free_idx]     <= wr_end;
         link_flag_ff[free_idx]    <= as_link;
         owner_tag_ff[free_idx]    <= req_tag_ff;
         insert_stamp_ff[free_idx] <= stamp_ff;
      end
   end

   // ---------------------------------------------------- response register
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [REM_W-1:0]  rsp_remaining_ff;
   logic [SLOT_W-1:0] rsp_aslot_ff;
   logic              rsp_linked_ff;
   logic [LAT_W-1:0]  rsp_wait_ff;
   logic              rsp_fin_ff;
   logic [TAG_W-1:0]  rsp_ftag_ff;
   err_code_type      rsp_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff       <= hit_in;
      rsp_remaining_ff <= remaining_in;
      rsp_aslot_ff     <= aslot_in;
      rsp_linked_ff    <= linked_in;
      rsp_wait_ff      <= wait_in;
      rsp_fin_ff       <= fin_in;
      rsp_ftag_ff      <= ftag_in;
      rsp_error_ff     <= err_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_remaining      = rsp_remaining_ff;
   assign rsp_assigned_slot  = rsp_aslot_ff;
   assign rsp_linked         = rsp_linked_ff;
   assign rsp_wait_cycles    = rsp_wait_ff;
   assign rsp_finished_valid = rsp_fin_ff;
   assign rsp_finished_tag   = rsp_ftag_ff;
   assign rsp_error          = rsp_error_ff;

   // ---------------------------------------------------------- assertions
`ifndef ASSERT_OFF
   // every registered request produces exactly one response from the response register
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_valid_ff == $past(req_valid_ff)))
      else $error("response strobe does not follow request register");

   // table full is reported only when every slot was occupied
   a_full: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && rsp_valid_ff && (rsp_error_ff == ERR_FULL))
         |-> $past(&entry_valid_ff))
      else $error("table full reported with a free slot");

   // a finished requester never comes with a hit
   a_fin_nohit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fin_ff) |-> !rsp_hit_ff)
      else $error("finished response carries a hit");

   // the stamp counter advances only when an entry is stored
   a_stamp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (stamp_ff != $past(stamp_ff)))
         |-> ($countones(entry_valid_ff) > 0))
      else $error("stamp counter advanced without a stored entry");
`endif

endmodule

`default_nettype wire

// File: rtl/core/msht_search.sv
// ----------------------------------------------------------------------------
// Miss status holding table search
// Line compare over all slots, oldest-match tree and lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module msht_search #(
   parameter int ENTRIES = msht_pkg::ENTRIES_DEFAULT
) (
   input  wire logic [((ENTRIES < 16) ? ENTRIES : 16)-1:0] entry_valid,
   input  wire logic [msht_pkg::ADDR_W-1:0]  line_address [(ENTRIES < 16) ? ENTRIES : 16],
   input  wire logic [msht_pkg::STAMP_W-1:0] insert_stamp [(ENTRIES < 16) ? ENTRIES : 16],
   input  wire logic [msht_pkg::STAMP_W-1:0] stamp_counter,
   input  wire logic [msht_pkg::ADDR_W-1:0]  line,
   output msht_pkg::search_type              result
);
   import msht_pkg::*;

   localparam int SlotLimit = (ENTRIES < 16) ? ENTRIES : 16;
   localparam int TreeSize  = 2 ** $clog2(SlotLimit);

   logic               node_ok  [2*TreeSize];
   logic [STAMP_W-1:0] node_age [2*TreeSize];
   logic [SLOT_W-1:0]  node_idx [2*TreeSize];
   logic               take_right;
   logic               free_found;
   logic [SLOT_W-1:0]  free_slot;

   // oldest match: heap-ordered tree, ties go to the lower slot
   always_comb begin
      for (int n = 0; n < 2*TreeSize; n++) begin
         node_ok[n]  = 1'b0;
         node_age[n] = '0;
         node_idx[n] = '0;
      end
      take_right = 1'b0;
      for (int k = 0; k < SlotLimit; k++) begin
         node_ok[TreeSize+k]  = entry_valid[k] && (line_address[k] == line);
         node_age[TreeSize+k] = stamp_counter - insert_stamp[k];
         node_idx[TreeSize+k] = SLOT_W'(k);
      end
      for (int n = TreeSize-1; n >= 1; n--) begin
         take_right = node_ok[2*n+1] &&
                      (!node_ok[2*n] || (node_age[2*n+1] > node_age[2*n]));
         if (take_right) begin
            node_ok[n]  = 1'b1;
            node_age[n] = node_age[2*n+1];
            node_idx[n] = node_idx[2*n+1];
         end else begin
            node_ok[n]  = node_ok[2*n];
            node_age[n] = node_age[2*n];
            node_idx[n] = node_idx[2*n];
         end
      end
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int k = SlotLimit-1; k >= 0; k--) begin
         if (!entry_valid[k]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(k);
         end
      end
   end

   assign result.hit        = node_ok[1];
   assign result.match_slot = node_idx[1];
   assign result.free_found = free_found;
   assign result.free_slot  = free_slot;

endmodule

`default_nettype wire
